/* hdl/fltm_pkg.sv */
// shared constants and types for the four-level page table map unit
`default_nettype none
package fltm_pkg;

   localparam int TABLE_FRAMES      = 16;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int FRAME_BITS        = $clog2(TABLE_FRAMES);
   localparam int INDEX_BITS        = $clog2(ENTRIES_PER_TABLE);
   localparam int ADDR_BITS         = FRAME_BITS + INDEX_BITS;
   localparam int NF_BITS           = $clog2(TABLE_FRAMES + 1);
   localparam int PAGE_SHIFT        = 12;
   localparam int VA_BITS           = 48;
   localparam int PA_BITS           = 52;
   localparam int FLAG_BITS         = 12;
   localparam int BASE_BITS         = 40;
   localparam int ENTRY_BITS        = 52;
   localparam int COUNT_BITS        = 5;
   localparam int LEVEL_BITS        = 2;

   localparam logic STATUS_MAPPED    = 1'b0;
   localparam logic STATUS_NO_FRAMES = 1'b1;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [ENTRY_BITS-1:0] entry_type;

   typedef struct packed {
      logic      we;
      addr_type  waddr;
      entry_type wdata;
      addr_type  raddr;
   } mem_req_type;

   typedef struct packed {
      logic                  valid;
      logic                  status;
      logic [PA_BITS-1:0]    leaf_entry;
      logic [COUNT_BITS-1:0] frames_in_use;
   } result_type;

endpackage
`default_nettype wire

/* hdl/fltm_table_ram.sv */
// table memory holding every pool frame, one write and one registered read port
`default_nettype none
module fltm_table_ram (
   input  wire                  clock,
   input  fltm_pkg::mem_req_type mem_req,
   output fltm_pkg::entry_type  rd_data
);

   fltm_pkg::entry_type mem [fltm_pkg::TABLE_FRAMES * fltm_pkg::ENTRIES_PER_TABLE];
   fltm_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/fltm_walker.sv */
// table walk sequencer with one shared frame adder
`default_nettype none
module fltm_walker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  [fltm_pkg::BASE_BITS-1:0]        base_frame,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [fltm_pkg::VA_BITS-1:0]          va_in,
   input  wire  [fltm_pkg::PA_BITS-1:0]          pa_in,
   input  wire  [fltm_pkg::FLAG_BITS-1:0]        flags_in,
   input  wire                                   out_free,
   output fltm_pkg::result_type                  result,
   output fltm_pkg::mem_req_type                 mem_req,
   input  fltm_pkg::entry_type                   rd_data
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_WIPE  = 3'd4;
   localparam logic [2:0] S_LINK  = 3'd5;
   localparam logic [2:0] S_LEAF  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                           state_ff, state_in;
   logic [fltm_pkg::VA_BITS-1:0]         va_ff, va_in_r;
   logic [fltm_pkg::PA_BITS-1:0]         pa_ff, pa_in_r;
   logic [fltm_pkg::FLAG_BITS-1:0]       fl_ff, fl_in;
   logic [fltm_pkg::LEVEL_BITS-1:0]      level_ff, level_in;
   logic [fltm_pkg::FRAME_BITS-1:0]      cur_ff, cur_in;
   logic [fltm_pkg::NF_BITS-1:0]         next_free_ff, next_free_in;
   logic [fltm_pkg::INDEX_BITS-1:0]      wipe_cnt_ff, wipe_cnt_in;
   fltm_pkg::addr_type                   slot_ff, slot_in;
   fltm_pkg::entry_type                  link_ff, link_in;
   logic                                 status_ff, status_in;
   logic [fltm_pkg::PA_BITS-1:0]         leaf_ff, leaf_in;

   logic [fltm_pkg::INDEX_BITS-1:0]      idx;
   logic                                 present;
   logic                                 pool_full;
   logic [fltm_pkg::BASE_BITS-1:0]       add_a, add_b, sum;
   logic                                 add_cin;
   fltm_pkg::entry_type                  leaf_val;

   // index field for the current level
   always_comb begin
      unique case (level_ff)
         2'd3:    idx = va_ff[fltm_pkg::PAGE_SHIFT + 3*fltm_pkg::INDEX_BITS +: fltm_pkg::INDEX_BITS];
         2'd2:    idx = va_ff[fltm_pkg::PAGE_SHIFT + 2*fltm_pkg::INDEX_BITS +: fltm_pkg::INDEX_BITS];
         2'd1:    idx = va_ff[fltm_pkg::PAGE_SHIFT + fltm_pkg::INDEX_BITS +: fltm_pkg::INDEX_BITS];
         default: idx = va_ff[fltm_pkg::PAGE_SHIFT +: fltm_pkg::INDEX_BITS];
      endcase
   end

   assign present   = rd_data[0];
   assign pool_full = next_free_ff >= fltm_pkg::NF_BITS'(fltm_pkg::TABLE_FRAMES);

   // shared adder: entry frame minus base, or base plus new frame
   assign add_a   = present ? rd_data[fltm_pkg::ENTRY_BITS-1:fltm_pkg::PAGE_SHIFT] : base_frame;
   assign add_b   = present ? ~base_frame
                            : fltm_pkg::BASE_BITS'(next_free_ff);
   assign add_cin = present;
   assign sum     = add_a + add_b + fltm_pkg::BASE_BITS'(add_cin);

   assign leaf_val = pa_ff | fltm_pkg::ENTRY_BITS'(fl_ff) | fltm_pkg::ENTRY_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      va_in_r      = va_ff;
      pa_in_r      = pa_ff;
      fl_in        = fl_ff;
      level_in     = level_ff;
      cur_in       = cur_ff;
      next_free_in = next_free_ff;
      wipe_cnt_in  = wipe_cnt_ff;
      slot_in      = slot_ff;
      link_in      = link_ff;
      status_in    = status_ff;
      leaf_in      = leaf_ff;
      mem_req      = '0;
      mem_req.raddr = {cur_ff, idx};
      req_ready    = 1'b0;

      unique case (state_ff)
         S_CLEAR, S_WIPE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {cur_ff, wipe_cnt_ff};
            mem_req.wdata = '0;
            wipe_cnt_in   = wipe_cnt_ff + 1'b1;
            if (&wipe_cnt_ff) begin
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_LINK;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               va_in_r  = va_in;
               pa_in_r  = pa_in;
               fl_in    = flags_in;
               level_in = 2'd3;
               cur_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            slot_in  = {cur_ff, idx};
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (present) begin
               cur_in   = sum[fltm_pkg::FRAME_BITS-1:0];
               level_in = level_ff - 1'b1;
               state_in = (level_ff == 2'd1) ? S_LEAF : S_READ;
            end else if (pool_full) begin
               status_in = fltm_pkg::STATUS_NO_FRAMES;
               leaf_in   = '0;
               state_in  = S_DONE;
            end else begin
               cur_in       = next_free_ff[fltm_pkg::FRAME_BITS-1:0];
               next_free_in = next_free_ff + 1'b1;
               link_in      = {sum, {fltm_pkg::PAGE_SHIFT{1'b0}}}
                              | fltm_pkg::ENTRY_BITS'(fl_ff) | fltm_pkg::ENTRY_BITS'(1);
               wipe_cnt_in  = '0;
               state_in     = S_WIPE;
            end
         end
         S_LINK: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_ff;
            mem_req.wdata = link_ff;
            level_in      = level_ff - 1'b1;
            state_in      = (level_ff == 2'd1) ? S_LEAF : S_READ;
         end
         S_LEAF: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {cur_ff, idx};
            mem_req.wdata = leaf_val;
            status_in     = fltm_pkg::STATUS_MAPPED;
            leaf_in       = leaf_val;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_ff       <= '0;
         wipe_cnt_ff  <= '0;
         next_free_ff <= fltm_pkg::NF_BITS'(1);
         level_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         wipe_cnt_ff  <= wipe_cnt_in;
         next_free_ff <= next_free_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff     <= va_in_r;
      pa_ff     <= pa_in_r;
      fl_ff     <= fl_in;
      slot_ff   <= slot_in;
      link_ff   <= link_in;
      status_ff <= status_in;
      leaf_ff   <= leaf_in;
   end

   assign result.valid         = (state_ff == S_DONE);
   assign result.status        = status_ff;
   assign result.leaf_entry    = leaf_ff;
   assign result.frames_in_use = fltm_pkg::COUNT_BITS'(next_free_ff);

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= fltm_pkg::NF_BITS'(fltm_pkg::TABLE_FRAMES))
      else $error("frame pool count out of range");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_req.we)
      else $error("table write outside a walk");

   a_full_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && !present && pool_full) |=>
      (state_ff == S_DONE && status_ff == fltm_pkg::STATUS_NO_FRAMES && leaf_ff == '0))
      else $error("pool exhaustion not reported");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(next_free_ff)) |->
      ($past(state_ff) == S_EVAL && next_free_ff == $past(next_free_ff) + 1'b1))
      else $error("frame counter moved outside allocation");

endmodule
`default_nettype wire

/* hdl/four_level_page_table_map_unit.sv */
// top level: installs 4 KiB x86-64 mappings into a private four-level table store
//
// req channel: one item per mapping (virtual address, physical address, flags).
// rsp channel: one item per request (status in tuser, leaf entry and frame count
// in tdata). csr channel: writes table_base_frame, always ready; write only
// while the block is idle.
// after reset every entry of the root frame is cleared; req_tready stays low
// until that pass ends.
// walk steps: each level reads its table entry, then checks it; a level that
// needs a new table also clears that table and then writes the link entry;
// the leaf entry is then written and the result handed to the output register.
// one request is walked at a time; req_tready is high only between walks, so
// a new request is taken only once the previous walk has handed off its result.
// results go to an output register, so the next request is taken while a
// result waits; a stalled receiver holds that register and a second finished
// walk waits in the sequencer until it drains.
`default_nettype none
module four_level_page_table_map_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [111:0] req_tdata,   // virtual_address[47:0], physical_address[99:48], entry_flags[111:100]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,   // leaf_entry[51:0], frames_in_use[56:52], zero[63:57]
   output logic [0:0]   rsp_tuser,   // status[0]
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [39:0]  csr_data     // table_base_frame
);

   logic [fltm_pkg::BASE_BITS-1:0] base_ff;
   logic                           rsp_valid_ff;
   logic [63:0]                    rsp_data_ff;
   logic                           rsp_user_ff;
   logic                           out_free;
   logic                           load;
   fltm_pkg::result_type           result;
   fltm_pkg::mem_req_type          mem_req;
   fltm_pkg::entry_type            rd_data;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load      = result.valid && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid) begin
         base_ff <= csr_data;
      end
   end

   fltm_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .base_frame (base_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .va_in      (req_tdata[47:0]),
      .pa_in      (req_tdata[99:48]),
      .flags_in   (req_tdata[111:100]),
      .out_free   (out_free),
      .result     (result),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   fltm_table_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= {7'd0, result.frames_in_use, result.leaf_entry};
         rsp_user_ff <= result.status;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule
`default_nettype wire

/* test/four_level_page_table_map_unit_test.sv */
// testbench for the four-level page table map unit: shadow page tables, stream stimulus, checks
module four_level_page_table_map_unit_test;
   import fltm_pkg::*;

   typedef struct {
      logic                  status;
      logic [ENTRY_BITS-1:0] leaf;
      logic [COUNT_BITS-1:0] frames;
   } mapping_result_type;

   typedef enum {READY_ALWAYS, READY_COIN, READY_RARE, READY_PERIODIC} ready_pattern_type;

   class page_map_scoreboard;
      logic [ENTRY_BITS-1:0] shadow_tables [TABLE_FRAMES][ENTRIES_PER_TABLE];
      int                    next_free;
      logic [BASE_BITS-1:0]  base_frame;
      mapping_result_type    expected_maps[$];
      int                    mismatches;

      function new();
         foreach (shadow_tables[f, i]) shadow_tables[f][i] = '0;
         next_free  = 1;
         base_frame = '0;
         mismatches = 0;
      endfunction

      function void set_base(logic [BASE_BITS-1:0] value);
         base_frame = value;
      endfunction

      // pool frame that a present entry points to
      function int follow(logic [ENTRY_BITS-1:0] entry);
         logic [BASE_BITS-1:0] diff;
         diff = entry[ENTRY_BITS-1:PAGE_SHIFT] - base_frame;
         return int'(diff[FRAME_BITS-1:0]);
      endfunction

      function logic [ENTRY_BITS-1:0] frame_address(int frame);
         logic [BASE_BITS-1:0] fn;
         fn = base_frame + BASE_BITS'(frame);
         return {fn, 12'h000};
      endfunction

      function void note_mapping(logic [VA_BITS-1:0] va, logic [PA_BITS-1:0] pa,
                                 logic [FLAG_BITS-1:0] fl);
         mapping_result_type    r;
         int                    cur;
         int                    parent;
         logic [INDEX_BITS-1:0] idx;
         logic [ENTRY_BITS-1:0] entry;
         cur = 0;
         for (int lvl = 3; lvl >= 1; lvl--) begin
            idx   = va[PAGE_SHIFT + INDEX_BITS * lvl +: INDEX_BITS];
            entry = shadow_tables[cur][idx];
            if (entry[0]) begin
               cur = follow(entry);
            end else if (next_free >= TABLE_FRAMES) begin
               r.status = STATUS_NO_FRAMES;
               r.leaf   = '0;
               r.frames = COUNT_BITS'(next_free);
               expected_maps.push_back(r);
               return;
            end else begin
               parent = cur;
               cur    = next_free;
               next_free++;
               for (int i = 0; i < ENTRIES_PER_TABLE; i++) shadow_tables[cur][i] = '0;
               shadow_tables[parent][idx] = frame_address(cur) | ENTRY_BITS'(fl) | 52'd1;
            end
         end
         idx      = va[PAGE_SHIFT +: INDEX_BITS];
         r.status = STATUS_MAPPED;
         r.leaf   = pa | ENTRY_BITS'(fl) | 52'd1;
         r.frames = COUNT_BITS'(next_free);
         shadow_tables[cur][idx] = r.leaf;
         expected_maps.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_mapping(logic status, logic [ENTRY_BITS-1:0] leaf,
                         logic [COUNT_BITS-1:0] frames);
         mapping_result_type e;
         if (expected_maps.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
            return;
         end
         e = expected_maps.pop_front();
         if (status !== e.status)
            report_mismatch($sformatf("status %b, expected %b", status, e.status));
         if (leaf !== e.leaf)
            report_mismatch($sformatf("leaf_entry %h, expected %h", leaf, e.leaf));
         if (frames !== e.frames)
            report_mismatch($sformatf("frames_in_use %0d, expected %0d", frames, e.frames));
      endtask
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [39:0]   csr_data   = '0;

   page_map_scoreboard sb = new();
   int                 burst_left   = 0;
   int                 pattern_left = 0;
   ready_pattern_type  stall_mode   = READY_ALWAYS;
   logic [BASE_BITS-1:0] phase_bases [4];

   four_level_page_table_map_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_mapping(req_tdata[47:0], req_tdata[99:48], req_tdata[111:100]);
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_mapping(rsp_tuser[0], rsp_tdata[51:0], rsp_tdata[56:52]);
   end

   always @(negedge clock) begin
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(20, 200);
         stall_mode   = ready_pattern_type'($urandom_range(0, 3));
      end
      pattern_left--;
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_RARE:     rsp_tready <= ($urandom_range(0, 7) == 0);
         READY_PERIODIC: rsp_tready <= (pattern_left % 4 != 0);
      endcase
   end

   // mostly follows present entries in the shadow tables, sometimes plain noise
   function automatic logic [VA_BITS-1:0] pick_address();
      logic [VA_BITS-1:0]    va;
      logic [INDEX_BITS-1:0] hits[$];
      int                    cur;
      va  = {16'($urandom), 32'($urandom)};
      cur = 0;
      if ($urandom_range(0, 4) == 0) return va;
      for (int lvl = 3; lvl >= 0; lvl--) begin
         hits.delete();
         for (int i = 0; i < ENTRIES_PER_TABLE; i++)
            if (sb.shadow_tables[cur][i][0]) hits.push_back(INDEX_BITS'(i));
         if (hits.size() == 0 || $urandom_range(0, 9) == 0) break;
         va[PAGE_SHIFT + INDEX_BITS * lvl +: INDEX_BITS] = hits[$urandom_range(0, hits.size() - 1)];
         if (lvl > 0)
            cur = sb.follow(sb.shadow_tables[cur][va[PAGE_SHIFT + INDEX_BITS * lvl +: INDEX_BITS]]);
      end
      return va;
   endfunction

   task send_request(logic [VA_BITS-1:0] va, logic [PA_BITS-1:0] pa, logic [FLAG_BITS-1:0] fl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {fl, pa, va};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task send_random();
      logic [PA_BITS-1:0] pa;
      pa = {20'($urandom), 32'($urandom)};
      if ($urandom_range(0, 3) != 0) pa[11:0] = '0;
      send_request(pick_address(), pa, FLAG_BITS'($urandom));
   endtask

   task wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_maps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      @(negedge clock);
   endtask

   task write_base(logic [BASE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_base(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      phase_bases[0] = 40'h00_0000_0000;
      phase_bases[1] = 40'(({$urandom, $urandom}));
      phase_bases[2] = 40'h80_0000_0000;
      phase_bases[3] = 40'(({$urandom, $urandom}));
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      // top of the 40-bit frame range, so the first pool table wraps to address zero
      write_base(40'hFF_FFFF_FFFF);

      send_request(48'h0000_0000_0000, 52'h0_0000_0000_0000, 12'h000);
      send_request(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
      send_request(48'h0000_0000_1000, 52'h0_0000_0ABC_D123, 12'h001);
      send_request(48'h0000_0000_0000, 52'h8_0000_0000_0000, 12'h800);
      send_request(48'h0000_0020_0000, 52'h1_2345_6789_A000, 12'h002);
      send_request(48'h0000_4000_0000, 52'h0_0000_0000_1000, 12'h004);
      send_request(48'h0000_0040_0000, 52'h7_FFFF_FFFF_F000, 12'h063);
      send_request(48'h0080_0000_0000, 52'h0_0000_1234_5000, 12'h107);
      // runs dry after two of its three tables
      send_request(48'h0100_0000_0000, 52'h3_0000_0000_0000, 12'h0F0);
      send_request(48'h0180_0000_0000, 52'h0_0000_0000_2000, 12'h000);
      send_request(48'hFFFF_FFFF_E000, 52'h0_0000_0000_0FFF, 12'h000);
      send_request(48'h8000_0000_0000, 52'h0_0000_0001_0000, 12'h001);
      send_request(48'h7FFF_FFFF_F000, 52'h0_0000_0002_0000, 12'h002);
      send_request(48'h0000_4000_1000, 52'h0_0000_0003_0000, 12'hF00);
      send_request(48'h0000_001F_F000, 52'h5_5555_5555_5555, 12'hAAA);
      send_request(48'h0000_0000_1000, 52'hA_AAAA_AAAA_AAAA, 12'h555);

      repeat (380) send_random();
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         write_base(phase_bases[p]);
         repeat (380) send_random();
      end
      wait_idle();

      if (sb.mismatches == 0 && sb.expected_maps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
